// ----- hw/rtl/afct_pkg.sv -----
// Shared types and constants for the box-versus-frustum culling block.
// Used by afct_plane_cell and aabb_frustum_cull_test_unit; depends on nothing.
`timescale 1ns / 1ps

package afct_pkg;

	// Box coordinate (signed Q12.4) and half extent (unsigned Q11.4).
	typedef logic signed [15:0] coord_t;
	typedef logic [14:0]        half_t;

	// One box as it travels down the chain of plane cells.
	typedef struct packed {
		coord_t cx;
		coord_t cy;
		coord_t cz;
		half_t  hx;
		half_t  hy;
		half_t  hz;
	} box_t;

	// Matrix entry (signed Q4.12) and one matrix row of four entries.
	typedef logic signed [15:0] mat_elem_t;
	typedef mat_elem_t [3:0]    mat_row_t;

	// Plane coefficient: sum or difference of two matrix entries.
	localparam int unsigned NORM_W = 17;
	typedef logic signed [NORM_W-1:0] norm_t;

	// Product widths, the scaled offset width and the width of the exact plane sum d + r.
	localparam int unsigned DOT_W = 33;
	localparam int unsigned RAD_W = 32;
	localparam int unsigned OFS_W = 21;
	localparam int unsigned SUM_W = 36;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned NUM_CFG    = 8;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_X_COLS01 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_X_COLS23 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_COLS01 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_COLS23 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Z_COLS01 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Z_COLS23 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_W_COLS01 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_W_COLS23 = 3'd7;

	// Reset values: the identity matrix.
	localparam logic [CFG_DATA_W-1:0] RST_ROW_X_COLS01 = 32'h0000_1000;
	localparam logic [CFG_DATA_W-1:0] RST_ROW_X_COLS23 = 32'h0000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_ROW_Y_COLS01 = 32'h1000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_ROW_Y_COLS23 = 32'h0000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_ROW_Z_COLS01 = 32'h0000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_ROW_Z_COLS23 = 32'h0000_1000;
	localparam logic [CFG_DATA_W-1:0] RST_ROW_W_COLS01 = 32'h0000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_ROW_W_COLS23 = 32'h1000_0000;

	// Number of frustum planes, and so of cells in the chain.
	localparam int unsigned PLANE_COUNT = 6;

endpackage

// ----- hw/rtl/afct_plane_cell.sv -----
// One cell of the culling chain: tests the passing box against one frustum plane.
// Depends on afct_pkg for the box, matrix row and width definitions.
`timescale 1ns / 1ps

module afct_plane_cell
	import afct_pkg::*;
#(
	parameter bit SUBTRACT = 1'b0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  mat_row_t row_r,
	input  mat_row_t row_w,
	input  logic     in_vld,
	output logic     in_rdy,
	input  box_t     in_box,
	input  logic     in_vis,
	output logic     out_vld,
	input  logic     out_rdy,
	output box_t     out_box,
	output logic     out_vis
);

	// Plane coefficients, formed from two rows of the matrix registers.
	norm_t norm [4];

	logic               vld_s1;
	box_t               box_s1;
	logic               vis_s1;
	logic signed [DOT_W-1:0] dot_s1 [3];
	logic [RAD_W-1:0]   rad_s1 [3];
	logic signed [OFS_W-1:0] ofs_s1;

	logic               vld_s2;
	box_t               box_s2;
	logic               vis_s2;

	logic               adv_s1;
	logic               adv_s2;
	logic signed [DOT_W-1:0] dot_d [3];
	logic [RAD_W-1:0]   rad_d [3];
	logic [NORM_W-1:0]  abs_n [3];
	coord_t             ctr [3];
	half_t              hlf [3];
	logic signed [SUM_W-1:0] plane_sum;

	// Plane normal and offset: fourth row plus or minus the selected row.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (SUBTRACT) begin
				norm[i] = norm_t'(row_w[i]) - norm_t'(row_r[i]);
			end else begin
				norm[i] = norm_t'(row_w[i]) + norm_t'(row_r[i]);
			end
		end
	end

	// A stage takes a new beat when it is empty or its beat moves on.
	assign adv_s2 = !vld_s2 || out_rdy;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign in_rdy = adv_s1;

	assign ctr[0] = in_box.cx;
	assign ctr[1] = in_box.cy;
	assign ctr[2] = in_box.cz;
	assign hlf[0] = in_box.hx;
	assign hlf[1] = in_box.hy;
	assign hlf[2] = in_box.hz;

	// Stage 1 products: normal times center, and half extent times |normal|.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			abs_n[i] = norm[i][NORM_W-1] ? (~norm[i] + 1'b1) : norm[i];
			dot_d[i] = norm[i] * ctr[i];
			rad_d[i] = hlf[i] * abs_n[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= in_vld;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			box_s1 <= in_box;
			vis_s1 <= in_vis;
			ofs_s1 <= {norm[3], 4'b0000};
			for (int i = 0; i < 3; i++) begin
				dot_s1[i] <= dot_d[i];
				rad_s1[i] <= rad_d[i];
			end
		end
	end

	// Stage 2: exact d + r; the box is culled when it is negative.
	always_comb begin
		plane_sum = SUM_W'(ofs_s1);
		for (int i = 0; i < 3; i++) begin
			plane_sum = plane_sum + SUM_W'(dot_s1[i])
				+ $signed({{(SUM_W-RAD_W){1'b0}}, rad_s1[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			box_s2 <= box_s1;
			vis_s2 <= vis_s1 && !plane_sum[SUM_W-1];
		end
	end

	assign out_vld = vld_s2;
	assign out_box = box_s2;
	assign out_vis = vis_s2;

endmodule

// ----- hw/rtl/aabb_frustum_cull_test_unit.sv -----
// Top level of the box-versus-frustum culling block: matrix registers and the plane chain.
// Depends on afct_pkg and afct_plane_cell.
`timescale 1ns / 1ps

// Usage
// Input channel: in_valid/in_stall with center_x/y/z (signed Q12.4) and
// half_x/y/z (unsigned Q11.4). A beat is taken when in_valid is high and
// in_stall is low. Output channel: out_valid/out_stall with visible, one beat
// per input beat, in order.
// The box passes through a chain of six plane cells, one per frustum plane,
// each two stages deep. Every box passes both stage registers of each cell;
// throughput is one box per cycle while out_stall is low.
// When out_stall is high the result holds; beats upstream keep moving into
// empty stages, and in_stall rises only once every stage is occupied.
// The configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready and writes one of eight matrix registers; write it only while the chain
// is empty. Asynchronous reset (arst_n low) empties the chain and loads the
// identity matrix.

module aabb_frustum_cull_test_unit
	import afct_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [15:0]    center_x,
	input  logic signed [15:0]    center_y,
	input  logic signed [15:0]    center_z,
	input  logic [14:0]           half_x,
	input  logic [14:0]           half_y,
	input  logic [14:0]           half_z,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  visible
);

	logic [CFG_DATA_W-1:0] cfg_q [NUM_CFG];
	mat_row_t              mat [4];

	box_t chain_box [PLANE_COUNT+1];
	logic chain_vld [PLANE_COUNT+1];
	logic chain_rdy [PLANE_COUNT+1];
	logic chain_vis [PLANE_COUNT+1];

	// Matrix registers: always ready, identity after reset.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_ROW_X_COLS01] <= RST_ROW_X_COLS01;
			cfg_q[REG_ROW_X_COLS23] <= RST_ROW_X_COLS23;
			cfg_q[REG_ROW_Y_COLS01] <= RST_ROW_Y_COLS01;
			cfg_q[REG_ROW_Y_COLS23] <= RST_ROW_Y_COLS23;
			cfg_q[REG_ROW_Z_COLS01] <= RST_ROW_Z_COLS01;
			cfg_q[REG_ROW_Z_COLS23] <= RST_ROW_Z_COLS23;
			cfg_q[REG_ROW_W_COLS01] <= RST_ROW_W_COLS01;
			cfg_q[REG_ROW_W_COLS23] <= RST_ROW_W_COLS23;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROW_X_COLS01: cfg_q[REG_ROW_X_COLS01] <= cfg_data;
				REG_ROW_X_COLS23: cfg_q[REG_ROW_X_COLS23] <= cfg_data;
				REG_ROW_Y_COLS01: cfg_q[REG_ROW_Y_COLS01] <= cfg_data;
				REG_ROW_Y_COLS23: cfg_q[REG_ROW_Y_COLS23] <= cfg_data;
				REG_ROW_Z_COLS01: cfg_q[REG_ROW_Z_COLS01] <= cfg_data;
				REG_ROW_Z_COLS23: cfg_q[REG_ROW_Z_COLS23] <= cfg_data;
				REG_ROW_W_COLS01: cfg_q[REG_ROW_W_COLS01] <= cfg_data;
				REG_ROW_W_COLS23: cfg_q[REG_ROW_W_COLS23] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Unpack the matrix: low half holds the even column, high half the odd one.
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			mat[r][0] = cfg_q[2*r][15:0];
			mat[r][1] = cfg_q[2*r][31:16];
			mat[r][2] = cfg_q[2*r+1][15:0];
			mat[r][3] = cfg_q[2*r+1][31:16];
		end
	end

	// Head of the chain: every box starts out visible.
	assign chain_vld[0]    = in_valid;
	assign chain_vis[0]    = 1'b1;
	assign chain_box[0].cx = center_x;
	assign chain_box[0].cy = center_y;
	assign chain_box[0].cz = center_z;
	assign chain_box[0].hx = half_x;
	assign chain_box[0].hy = half_y;
	assign chain_box[0].hz = half_z;
	assign in_stall        = !chain_rdy[0];

	// Six plane cells: row k added to, then subtracted from, the fourth row.
	for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
		afct_plane_cell #(
			.SUBTRACT (1'(p % 2))
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.row_r   (mat[p/2]),
			.row_w   (mat[3]),
			.in_vld  (chain_vld[p]),
			.in_rdy  (chain_rdy[p]),
			.in_box  (chain_box[p]),
			.in_vis  (chain_vis[p]),
			.out_vld (chain_vld[p+1]),
			.out_rdy (chain_rdy[p+1]),
			.out_box (chain_box[p+1]),
			.out_vis (chain_vis[p+1])
		);
	end

	// Tail of the chain: the last cell's stage register drives the output.
	assign chain_rdy[PLANE_COUNT] = !out_stall;
	assign out_valid              = chain_vld[PLANE_COUNT];
	assign visible                = chain_vis[PLANE_COUNT];

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the box-versus-frustum culling unit.
// It holds a scoreboard class that predicts each visible bit and plain tasks that drive the
// block. It depends on afct_pkg and aabb_frustum_cull_test_unit.
`timescale 1ns / 1ps

module tb_top
	import afct_pkg::*;
;

	typedef logic [CFG_DATA_W-1:0] mat_regs_t [NUM_CFG];

	localparam mat_regs_t IDENTITY = '{RST_ROW_X_COLS01, RST_ROW_X_COLS23,
		RST_ROW_Y_COLS01, RST_ROW_Y_COLS23, RST_ROW_Z_COLS01, RST_ROW_Z_COLS23,
		RST_ROW_W_COLS01, RST_ROW_W_COLS23};
	localparam logic [CFG_IDX_W-1:0] REG_ORDER [NUM_CFG] = '{REG_ROW_X_COLS01,
		REG_ROW_X_COLS23, REG_ROW_Y_COLS01, REG_ROW_Y_COLS23, REG_ROW_Z_COLS01,
		REG_ROW_Z_COLS23, REG_ROW_W_COLS01, REG_ROW_W_COLS23};

	localparam int HOLD_CYCLES  = 80;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_SETS  = 11;

	// Predicts the visible bit of each accepted box and checks the output beats in order.
	class cull_scoreboard;
		mat_regs_t mat_regs;
		bit        visible_q[$];
		int        errors;
		int        seen_visible;
		int        seen_culled;

		function new();
			mat_regs     = IDENTITY;
			errors       = 0;
			seen_visible = 0;
			seen_culled  = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx < NUM_CFG) begin
				mat_regs[idx] = data;
			end
		endfunction

		// One signed Q4.12 matrix entry, widened so that all later sums stay exact.
		function longint entry(int row, int col);
			logic [CFG_DATA_W-1:0] word;
			word = mat_regs[2 * row + col / 2];
			if (col % 2 == 0) begin
				return longint'($signed(word[15:0]));
			end
			return longint'($signed(word[31:16]));
		endfunction

		// Tests the box against the six planes built from the W row plus or minus X, Y and Z.
		function bit box_in_frustum(box_t b);
			longint ctr[3];
			longint half[3];
			longint nrm[4];
			longint plane_d;
			longint rad;
			bit     vis;
			vis     = 1'b1;
			ctr[0]  = longint'($signed(b.cx));
			ctr[1]  = longint'($signed(b.cy));
			ctr[2]  = longint'($signed(b.cz));
			half[0] = longint'(b.hx);
			half[1] = longint'(b.hy);
			half[2] = longint'(b.hz);
			for (int k = 0; k < 3; k++) begin
				for (int s = 0; s < 2; s++) begin
					for (int i = 0; i < 4; i++) begin
						nrm[i] = (s == 0) ? entry(3, i) + entry(k, i) : entry(3, i) - entry(k, i);
					end
					// The offset is Q.12 and the products are Q.16, so scale it by 16.
					plane_d = nrm[3] * 16;
					rad     = 0;
					for (int i = 0; i < 3; i++) begin
						plane_d += nrm[i] * ctr[i];
						rad     += half[i] * ((nrm[i] < 0) ? -nrm[i] : nrm[i]);
					end
					// Strict compare: a box that only touches the plane stays visible.
					if (plane_d < -rad) begin
						vis = 1'b0;
					end
				end
			end
			return vis;
		endfunction

		function void note_box(box_t b);
			visible_q.push_back(box_in_frustum(b));
		endfunction

		function void check_visible(logic got);
			bit want;
			if (visible_q.size() == 0) begin
				$display("%0t: unexpected beat: expected none, actual visible=%0b", $time, got);
				errors++;
				return;
			end
			want = visible_q.pop_front();
			if (got !== want) begin
				$display("%0t: visible mismatch: expected %0b, actual %0b", $time, want, got);
				errors++;
			end
			if (want) begin
				seen_visible++;
			end else begin
				seen_culled++;
			end
		endfunction

		function int pending();
			return visible_q.size();
		endfunction

		function void flush_leftover();
			while (visible_q.size() > 0) begin
				$display("%0t: missing beat: expected visible=%0b, actual none", $time,
					visible_q.pop_front());
				errors++;
			end
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic signed [15:0]    center_x  = '0;
	logic signed [15:0]    center_y  = '0;
	logic signed [15:0]    center_z  = '0;
	logic [14:0]           half_x    = '0;
	logic [14:0]           half_y    = '0;
	logic [14:0]           half_z    = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  visible;

	cull_scoreboard sb = new();
	int  idle_pct     = 0;
	int  stall_pct    = 0;
	bit  hold_req     = 1'b0;
	int  quiet_cycles = 0;
	int  n_settings   = 1;

	aabb_frustum_cull_test_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.center_x (center_x),
		.center_y (center_y),
		.center_z (center_z),
		.half_x   (half_x),
		.half_y   (half_y),
		.half_z   (half_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.visible  (visible)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: random stalls, plus one long hold-off whenever the main flow asks for it.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Output monitor: every accepted beat goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_visible(visible);
		end
	end

	// Watchdog: too long without any beat on any channel ends the run.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic box_t mk_box(int cx, int cy, int cz, int hx, int hy, int hz);
		box_t b;
		b.cx = 16'(cx);
		b.cy = 16'(cy);
		b.cz = 16'(cz);
		b.hx = 15'(hx);
		b.hy = 15'(hy);
		b.hz = 15'(hz);
		return b;
	endfunction

	// A random box at a random scale; the widest scale covers every bit of every field.
	function automatic box_t rand_box();
		box_t b;
		int   sh;
		sh   = $urandom_range(12);
		b.cx = $signed(16'($urandom)) >>> sh;
		b.cy = $signed(16'($urandom)) >>> sh;
		b.cz = $signed(16'($urandom)) >>> sh;
		b.hx = 15'($urandom) >> sh;
		b.hy = 15'($urandom) >> sh;
		b.hz = 15'($urandom) >> sh;
		return b;
	endfunction

	// Matrix entries: full range, within about one, zero, or exactly plus or minus one.
	function automatic logic [15:0] rand_entry();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($signed(16'($urandom)) >>> 3);
			2: return 16'h0000;
			default: return ($urandom_range(1) != 0) ? 16'h1000 : 16'hF000;
		endcase
	endfunction

	function automatic mat_regs_t random_matrix();
		mat_regs_t m;
		for (int i = 0; i < NUM_CFG; i++) begin
			m[i] = {rand_entry(), rand_entry()};
		end
		return m;
	endfunction

	// Every entry of rows X, Y and Z is r_val and every entry of row W is w_val.
	function automatic mat_regs_t uniform_rows(logic [15:0] w_val, logic [15:0] r_val);
		mat_regs_t m;
		for (int i = 0; i < NUM_CFG; i++) begin
			m[i] = (REG_ORDER[i] >= REG_ROW_W_COLS01) ? {w_val, w_val} : {r_val, r_val};
		end
		return m;
	endfunction

	// Offers one box after a random gap and waits until the beat is taken.
	task automatic send_box(box_t b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		center_x <= b.cx;
		center_y <= b.cy;
		center_z <= b.cz;
		half_x   <= b.hx;
		half_y   <= b.hy;
		half_z   <= b.hz;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_box(b);
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(int n);
		repeat (n) send_box(rand_box());
		end_burst();
	endtask

	// Waits until the chain is empty, then writes all eight matrix registers.
	task automatic set_matrix(mat_regs_t m);
		while (sb.pending() > 0) begin
			@(posedge clk);
		end
		for (int i = 0; i < NUM_CFG; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= REG_ORDER[i];
			cfg_data  <= m[i];
			@(posedge clk);
			while (!cfg_ready) begin
				@(posedge clk);
			end
			sb.write_reg(REG_ORDER[i], m[i]);
		end
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	initial begin
		mat_regs_t m;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity matrix after reset: field extremes and boxes touching the planes.
		send_box(mk_box(0, 0, 0, 0, 0, 0));
		send_box(mk_box(32767, 32767, 32767, 0, 0, 0));
		send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
		send_box(mk_box(32767, -32768, 0, 32767, 32767, 0));
		send_box(mk_box(-32, 0, 0, 16, 0, 0));
		send_box(mk_box(-33, 0, 0, 16, 0, 0));
		send_box(mk_box(32, 0, 0, 16, 0, 0));
		send_box(mk_box(33, 0, 0, 16, 0, 0));
		send_box(mk_box(0, -32, 0, 0, 16, 0));
		send_box(mk_box(0, 0, 33, 0, 0, 16));
		send_box(mk_box(16, -16, 16, 0, 0, 0));
		end_burst();
		run_random(150);

		// Zero normal with a negative offset: every box is culled.
		m = IDENTITY;
		m[REG_ROW_X_COLS01] = 32'h0000_0000;
		m[REG_ROW_X_COLS23] = 32'h2000_0000;
		set_matrix(m);
		send_box(mk_box(0, 0, 0, 0, 0, 0));
		send_box(mk_box(-32768, 32767, 0, 32767, 32767, 32767));
		end_burst();
		idle_pct = 61;
		run_random(40);

		// Zero normal with a zero offset: that plane never culls.
		m[REG_ROW_X_COLS23] = 32'h1000_0000;
		set_matrix(m);
		send_box(mk_box(0, 0, 0, 0, 0, 0));
		send_box(mk_box(0, 33, 0, 0, 16, 0));
		end_burst();
		idle_pct  = 0;
		stall_pct = 61;
		run_random(40);

		// Extreme matrices: all zero, all maximum, all minimum, and mixed.
		set_matrix(uniform_rows(16'h0000, 16'h0000));
		run_random(30);
		set_matrix(uniform_rows(16'h7FFF, 16'h7FFF));
		idle_pct  = 61;
		stall_pct = 0;
		run_random(60);
		set_matrix(uniform_rows(16'h8000, 16'h8000));
		idle_pct  = 0;
		stall_pct = 61;
		run_random(60);
		set_matrix(uniform_rows(16'h7FFF, 16'h8000));
		idle_pct  = 21;
		stall_pct = 21;
		run_random(60);

		// Random matrices, cycling through the traffic patterns.
		for (int p = 0; p < RANDOM_SETS; p++) begin
			set_matrix(random_matrix());
			case (p % 4)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
					hold_req  = 1'b1;
				end
				1: begin
					idle_pct  = 61;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 61;
				end
				default: begin
					idle_pct  = 21;
					stall_pct = 21;
				end
			endcase
			run_random(100);
		end

		while (sb.pending() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.flush_leftover();

		$display("Checked %0d boxes (%0d visible, %0d culled) under %0d matrix settings,",
			sb.seen_visible + sb.seen_culled, sb.seen_visible, sb.seen_culled, n_settings);
		$display("with sender gaps, receiver stalls and long output hold-offs.");
		if (sb.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/afct_pkg.sv
hw/rtl/afct_plane_cell.sv
hw/rtl/aabb_frustum_cull_test_unit.sv
tb/tb_top.sv
